// File: rtl/sloc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sloc_pkg
// Shared codes and controller/datapath interface types for the shifted label
// overlap counter.
// ----------------------------------------------------------------------------
package sloc_pkg;

	localparam logic [1:0] OP_VOXEL  = 2'd0;
	localparam logic [1:0] OP_LAG    = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	localparam logic [2:0] CFG_AXES  = 3'd0;
	localparam logic [2:0] CFG_EXT0  = 3'd1;
	localparam logic [2:0] CFG_EXT1  = 3'd2;
	localparam logic [2:0] CFG_EXT2  = 3'd3;
	localparam logic [2:0] CFG_DSH0  = 3'd4;
	localparam logic [2:0] CFG_DSH1  = 3'd5;
	localparam logic [2:0] CFG_DSH2  = 3'd6;
	localparam logic [2:0] CFG_ROOM  = 3'd7;

	localparam int AXES        = 3;
	localparam int LABEL_W     = 32;
	localparam int COORD_W     = 13;
	localparam int TALLY_W     = 13;
	localparam int ROOM_W      = 6;
	localparam int KEY_W       = 2 * LABEL_W;
	localparam int VOX_W       = 2 * LABEL_W + 2;
	localparam int PAIR_W      = KEY_W + TALLY_W;

	typedef struct packed {
		logic load_vox;
		logic load_lag;
		logic init_job;
		logic set_refuse;
		logic prod_step;
		logic vox_rd;
		logic latch_before;
		logic lag_init;
		logic lag_step;
		logic lag_resolve;
		logic move_step;
		logic after_rd;
		logic latch_key;
		logic pair_rd_mid;
		logic pair_step;
		logic pair_rd_lo;
		logic hit_wr;
		logic ins_init;
		logic sh_rd;
		logic sh_wr;
		logic ins_wr;
		logic advance;
		logic emit_init;
		logic emit_rd;
		logic emit_out;
		logic sum_out;
		logic job_clear;
	} sloc_cmd_t;

	typedef struct packed {
		logic pre_refuse;
		logic prod_last;
		logic prod_ok;
		logic scan_done;
		logic before_flag;
		logic lag_busy;
		logic move_out;
		logic move_last;
		logic after_flag;
		logic pair_search;
		logic lo_lt_total;
		logic key_eq;
		logic table_full;
		logic ins_done;
		logic emit_all;
		logic emit_done;
	} sloc_sts_t;

endpackage
`default_nettype wire

// File: rtl/sloc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sloc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                                       clk,
	input  wire                                       we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                          wdata,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/sloc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sloc_ctrl
// Job sequencer: loads, geometry check, voxel scan, pair table search and
// sorted insert, result emission.
// ----------------------------------------------------------------------------
module sloc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire  [1:0]           opcode,
	input  sloc_pkg::sloc_sts_t  sts,
	output sloc_pkg::sloc_cmd_t  cmd,
	output logic                 busy
);
	import sloc_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_PROD  = 18'h00002,
		S_PCMP  = 18'h00004,
		S_VRD   = 18'h00008,
		S_VDAT  = 18'h00010,
		S_LAG   = 18'h00020,
		S_MOVE  = 18'h00040,
		S_ARD   = 18'h00080,
		S_ADAT  = 18'h00100,
		S_PRD   = 18'h00200,
		S_PCMPK = 18'h00400,
		S_PHIT  = 18'h00800,
		S_PINS  = 18'h01000,
		S_SHRD  = 18'h02000,
		S_SHWR  = 18'h04000,
		S_ERD   = 18'h08000,
		S_EOUT  = 18'h10000,
		S_SUM   = 18'h20000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_vox = start && (opcode == OP_VOXEL);
				cmd.load_lag = start && (opcode == OP_LAG);
				if (start && (opcode == OP_FINISH)) begin
					cmd.init_job = 1'b1;
					if (sts.pre_refuse) begin
						cmd.set_refuse = 1'b1;
						state_d        = S_SUM;
					end else begin
						state_d = S_PROD;
					end
				end
			end
			S_PROD: begin
				cmd.prod_step = 1'b1;
				if (sts.prod_last) begin
					state_d = S_PCMP;
				end
			end
			S_PCMP: begin
				if (!sts.prod_ok) begin
					cmd.set_refuse = 1'b1;
					state_d        = S_SUM;
				end else begin
					state_d = S_VRD;
				end
			end
			S_VRD: begin
				if (sts.scan_done) begin
					if (sts.emit_all) begin
						cmd.emit_init = 1'b1;
						state_d       = S_ERD;
					end else begin
						state_d = S_SUM;
					end
				end else begin
					cmd.vox_rd = 1'b1;
					state_d    = S_VDAT;
				end
			end
			S_VDAT: begin
				cmd.latch_before = 1'b1;
				if (!sts.before_flag) begin
					cmd.advance = 1'b1;
					state_d     = S_VRD;
				end else begin
					cmd.lag_init = 1'b1;
					state_d      = S_LAG;
				end
			end
			S_LAG: begin
				if (sts.lag_busy) begin
					cmd.lag_step = 1'b1;
				end else begin
					cmd.lag_resolve = 1'b1;
					state_d         = S_MOVE;
				end
			end
			S_MOVE: begin
				if (sts.move_out) begin
					cmd.advance = 1'b1;
					state_d     = S_VRD;
				end else begin
					cmd.move_step = 1'b1;
					if (sts.move_last) begin
						state_d = S_ARD;
					end
				end
			end
			S_ARD: begin
				cmd.after_rd = 1'b1;
				state_d      = S_ADAT;
			end
			S_ADAT: begin
				if (!sts.after_flag) begin
					cmd.advance = 1'b1;
					state_d     = S_VRD;
				end else begin
					cmd.latch_key = 1'b1;
					state_d       = S_PRD;
				end
			end
			S_PRD: begin
				priority if (sts.pair_search) begin
					cmd.pair_rd_mid = 1'b1;
					state_d         = S_PCMPK;
				end else if (sts.lo_lt_total) begin
					cmd.pair_rd_lo = 1'b1;
					state_d        = S_PHIT;
				end else begin
					state_d = S_PINS;
				end
			end
			S_PCMPK: begin
				cmd.pair_step = 1'b1;
				state_d       = S_PRD;
			end
			S_PHIT: begin
				if (sts.key_eq) begin
					cmd.hit_wr  = 1'b1;
					cmd.advance = 1'b1;
					state_d     = S_VRD;
				end else begin
					state_d = S_PINS;
				end
			end
			S_PINS: begin
				if (sts.table_full) begin
					cmd.set_refuse = 1'b1;
					state_d        = S_SUM;
				end else begin
					cmd.ins_init = 1'b1;
					state_d      = S_SHRD;
				end
			end
			S_SHRD: begin
				if (sts.ins_done) begin
					cmd.ins_wr  = 1'b1;
					cmd.advance = 1'b1;
					state_d     = S_VRD;
				end else begin
					cmd.sh_rd = 1'b1;
					state_d   = S_SHWR;
				end
			end
			S_SHWR: begin
				cmd.sh_wr = 1'b1;
				state_d   = S_SHRD;
			end
			S_ERD: begin
				if (sts.emit_done) begin
					state_d = S_SUM;
				end else begin
					cmd.emit_rd = 1'b1;
					state_d     = S_EOUT;
				end
			end
			S_EOUT: begin
				cmd.emit_out = 1'b1;
				state_d      = S_ERD;
			end
			S_SUM: begin
				cmd.sum_out   = 1'b1;
				cmd.job_clear = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/sloc_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sloc_dpath
// Datapath: configuration registers, voxel store, lag table, coordinate
// walk, pair table and result register.
// ----------------------------------------------------------------------------
module sloc_dpath #(
	parameter int MAX_VOXELS  = 4096,
	parameter int MAX_AXES    = 3,
	parameter int PAIR_LIMIT  = 63,
	parameter int LAG_ENTRIES = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sloc_pkg::sloc_cmd_t  cmd,
	output sloc_pkg::sloc_sts_t  sts,
	input  wire                  cfg_we,
	input  wire  [2:0]           cfg_index,
	input  wire  [12:0]          cfg_data,
	input  wire  [31:0]          label_before,
	input  wire                  present_before,
	input  wire  [31:0]          label_after,
	input  wire                  present_after,
	input  wire  [31:0]          lag_label,
	input  wire  signed [12:0]   lag_step_0,
	input  wire  signed [12:0]   lag_step_1,
	input  wire  signed [12:0]   lag_step_2,
	output logic                 result_valid,
	output logic                 refused,
	output logic [5:0]           distinct_pairs,
	output logic [31:0]          pair_before,
	output logic [31:0]          pair_after,
	output logic [12:0]          pair_count,
	output logic                 last
);
	import sloc_pkg::*;

	localparam int AW   = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
	localparam int VW   = $clog2(MAX_VOXELS + 1);
	localparam int LIW  = (LAG_ENTRIES > 1) ? $clog2(LAG_ENTRIES) : 1;
	localparam int LW   = $clog2(LAG_ENTRIES + 1);
	localparam int PAW  = (PAIR_LIMIT > 1) ? $clog2(PAIR_LIMIT) : 1;
	localparam int PTW  = $clog2(PAIR_LIMIT + 1);

	// configuration
	logic [1:0]             axes_q;
	logic [COORD_W-1:0]     ext_q [AXES];
	logic signed [12:0]     dsh_q [AXES];
	logic [ROOM_W-1:0]      room_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axes_q <= 2'd3;
			for (int i = 0; i < AXES; i++) begin
				ext_q[i] <= 13'd16;
				dsh_q[i] <= '0;
			end
			room_q <= 6'd63;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AXES: axes_q   <= cfg_data[1:0];
				CFG_EXT0: ext_q[0] <= cfg_data;
				CFG_EXT1: ext_q[1] <= cfg_data;
				CFG_EXT2: ext_q[2] <= cfg_data;
				CFG_DSH0: dsh_q[0] <= cfg_data;
				CFG_DSH1: dsh_q[1] <= cfg_data;
				CFG_DSH2: dsh_q[2] <= cfg_data;
				CFG_ROOM: room_q   <= cfg_data[ROOM_W-1:0];
				default:  ;
			endcase
		end
	end

	// job control state
	logic [VW-1:0]   vc_q;
	logic [LW-1:0]   lag_cnt_q;
	logic            ovf_q;
	logic            refuse_q;
	logic [PTW-1:0]  total_q;

	logic vox_room, lag_room;
	assign vox_room = (vc_q < VW'(MAX_VOXELS));
	assign lag_room = (lag_cnt_q < LW'(LAG_ENTRIES));

	// voxel store
	logic [VOX_W-1:0] vox_rdata;
	logic [AW-1:0]    vox_raddr;
	logic [AW-1:0]    m_q;
	logic [VW-1:0]    v_q;

	assign vox_raddr = cmd.vox_rd ? v_q[AW-1:0] : m_q;

	sloc_ram #(
		.WIDTH (VOX_W),
		.DEPTH (MAX_VOXELS)
	) u_vox_ram (
		.clk   (clk),
		.we    (cmd.load_vox && vox_room),
		.waddr (vc_q[AW-1:0]),
		.wdata ({label_before, present_before, label_after, present_after}),
		.raddr (vox_raddr),
		.rdata (vox_rdata)
	);

	// lag table
	logic [LABEL_W-1:0]  lag_lbl_q [LAG_ENTRIES];
	logic signed [12:0]  lag_sh_q  [LAG_ENTRIES][AXES];
	logic [LW-1:0]       llo_q, lhi_q, lmid;
	logic [LIW-1:0]      lidx;
	logic [LABEL_W-1:0]  blabel_q;
	logic signed [12:0]  sh_q [AXES];
	logic                lag_hit;

	assign lmid = llo_q + ((lhi_q - llo_q) >> 1);
	assign lidx = sts.lag_busy ? lmid[LIW-1:0] : llo_q[LIW-1:0];
	assign lag_hit = (llo_q < lag_cnt_q) && (lag_lbl_q[lidx] == blabel_q);

	always_ff @(posedge clk) begin
		if (cmd.load_lag && lag_room) begin
			lag_lbl_q[lag_cnt_q[LIW-1:0]]    <= lag_label;
			lag_sh_q[lag_cnt_q[LIW-1:0]][0]  <= lag_step_0;
			lag_sh_q[lag_cnt_q[LIW-1:0]][1]  <= lag_step_1;
			lag_sh_q[lag_cnt_q[LIW-1:0]][2]  <= lag_step_2;
		end
		if (cmd.latch_before) begin
			blabel_q <= vox_rdata[VOX_W-1 -: LABEL_W];
		end
		if (cmd.lag_init) begin
			llo_q <= '0;
			lhi_q <= lag_cnt_q;
		end else if (cmd.lag_step) begin
			if (lag_lbl_q[lidx] < blabel_q) begin
				llo_q <= lmid + LW'(1);
			end else begin
				lhi_q <= lmid;
			end
		end
		if (cmd.lag_resolve) begin
			for (int i = 0; i < AXES; i++) begin
				sh_q[i] <= lag_hit ? lag_sh_q[lidx][i] : dsh_q[i];
			end
		end
	end

	// coordinate walk and moved address
	logic [COORD_W-1:0]   coord_q [AXES];
	logic [COORD_W-1:0]   coord_d [AXES];
	logic [1:0]           ax_q;
	logic signed [14:0]   csum;
	logic [AW+13:0]       mm;
	logic [VW:0]          prod_q;
	logic [VW+13:0]       pmul;

	assign csum = $signed({2'b00, coord_q[ax_q]}) + $signed({{2{sh_q[ax_q][12]}}, sh_q[ax_q]});
	assign mm   = (AW+14)'(m_q) * (AW+14)'(ext_q[ax_q]) + (AW+14)'(csum[12:0]);
	assign pmul = (VW+14)'(prod_q) * (VW+14)'(ext_q[ax_q]);

	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int i = AXES - 1; i >= 0; i--) begin
			coord_d[i] = coord_q[i];
			if (carry && (2'(i) < axes_q)) begin
				if (coord_q[i] == ext_q[i] - 13'd1) begin
					coord_d[i] = '0;
				end else begin
					coord_d[i] = coord_q[i] + 13'd1;
					carry      = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_job) begin
			v_q    <= '0;
			ax_q   <= '0;
			prod_q <= (VW+1)'(1);
			for (int i = 0; i < AXES; i++) begin
				coord_q[i] <= '0;
			end
		end else begin
			if (cmd.advance) begin
				v_q     <= v_q + VW'(1);
				coord_q <= coord_d;
			end
			if (cmd.prod_step) begin
				ax_q   <= ax_q + 2'd1;
				prod_q <= (|pmul[VW+13:VW+1]) ? '1 : pmul[VW:0];
			end
			if (cmd.lag_resolve) begin
				ax_q <= '0;
				m_q  <= '0;
			end
			if (cmd.move_step) begin
				ax_q <= ax_q + 2'd1;
				m_q  <= mm[AW-1:0];
			end
		end
	end

	// pair table
	logic [PAIR_W-1:0]   pr_rdata;
	logic [KEY_W-1:0]    rkey;
	logic [TALLY_W-1:0]  rtally;
	logic [KEY_W-1:0]    key_q;
	logic [PTW-1:0]      plo_q, phi_q, pmid, j_q;
	logic [PAW-1:0]      pr_raddr, pr_waddr;
	logic [PAIR_W-1:0]   pr_wdata;
	logic                pr_we;

	assign rkey   = pr_rdata[PAIR_W-1 -: KEY_W];
	assign rtally = pr_rdata[TALLY_W-1:0];
	assign pmid   = plo_q + ((phi_q - plo_q) >> 1);

	always_comb begin
		priority if (cmd.pair_rd_mid) begin
			pr_raddr = pmid[PAW-1:0];
		end else if (cmd.pair_rd_lo) begin
			pr_raddr = plo_q[PAW-1:0];
		end else if (cmd.sh_rd) begin
			pr_raddr = PAW'(j_q - PTW'(1));
		end else begin
			pr_raddr = j_q[PAW-1:0];
		end
	end

	always_comb begin
		pr_we    = cmd.hit_wr || cmd.sh_wr || cmd.ins_wr;
		pr_waddr = plo_q[PAW-1:0];
		pr_wdata = {key_q, TALLY_W'(1)};
		priority if (cmd.hit_wr) begin
			pr_wdata = {rkey, (&rtally) ? rtally : rtally + TALLY_W'(1)};
		end else if (cmd.sh_wr) begin
			pr_waddr = j_q[PAW-1:0];
			pr_wdata = pr_rdata;
		end else begin
			pr_wdata = {key_q, TALLY_W'(1)};
		end
	end

	sloc_ram #(
		.WIDTH (PAIR_W),
		.DEPTH (PAIR_LIMIT)
	) u_pair_ram (
		.clk   (clk),
		.we    (pr_we),
		.waddr (pr_waddr),
		.wdata (pr_wdata),
		.raddr (pr_raddr),
		.rdata (pr_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_key) begin
			key_q <= {blabel_q, vox_rdata[LABEL_W:1]};
			plo_q <= '0;
			phi_q <= total_q;
		end else if (cmd.pair_step) begin
			if (rkey < key_q) begin
				plo_q <= pmid + PTW'(1);
			end else begin
				phi_q <= pmid;
			end
		end
		if (cmd.ins_init) begin
			j_q <= total_q;
		end else if (cmd.emit_init) begin
			j_q <= '0;
		end else if (cmd.sh_wr) begin
			j_q <= j_q - PTW'(1);
		end else if (cmd.emit_out) begin
			j_q <= j_q + PTW'(1);
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q      <= '0;
			lag_cnt_q <= '0;
			ovf_q     <= 1'b0;
			refuse_q  <= 1'b0;
			total_q   <= '0;
		end else begin
			if (cmd.load_vox) begin
				if (vox_room) begin
					vc_q <= vc_q + VW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.load_lag) begin
				if (lag_room) begin
					lag_cnt_q <= lag_cnt_q + LW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.set_refuse) begin
				refuse_q <= 1'b1;
			end else if (cmd.init_job) begin
				refuse_q <= 1'b0;
			end
			if (cmd.init_job || cmd.job_clear) begin
				total_q <= '0;
			end else if (cmd.ins_wr) begin
				total_q <= total_q + PTW'(1);
			end
			if (cmd.job_clear) begin
				vc_q      <= '0;
				lag_cnt_q <= '0;
				ovf_q     <= 1'b0;
			end
		end
	end

	// status
	always_comb begin
		sts.pre_refuse  = ovf_q || (vc_q == '0) || (axes_q == 2'd0) ||
		                  (32'(axes_q) > MAX_AXES) || (32'(room_q) > PAIR_LIMIT);
		sts.prod_last   = (ax_q == axes_q - 2'd1);
		sts.prod_ok     = (prod_q == {1'b0, vc_q});
		sts.scan_done   = (v_q == vc_q);
		sts.before_flag = vox_rdata[LABEL_W+1];
		sts.lag_busy    = (llo_q < lhi_q);
		sts.move_out    = csum[14] || (csum[13:0] >= {1'b0, ext_q[ax_q]});
		sts.move_last   = (ax_q == axes_q - 2'd1);
		sts.after_flag  = vox_rdata[0];
		sts.pair_search = (plo_q < phi_q);
		sts.lo_lt_total = (plo_q < total_q);
		sts.key_eq      = (rkey == key_q);
		sts.table_full  = (32'(total_q) >= PAIR_LIMIT);
		sts.ins_done    = (j_q == plo_q);
		sts.emit_all    = (32'(total_q) <= 32'(room_q));
		sts.emit_done   = (j_q == total_q);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit_out || cmd.sum_out;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_out) begin
			refused        <= 1'b0;
			distinct_pairs <= '0;
			pair_before    <= rkey[KEY_W-1 -: LABEL_W];
			pair_after     <= rkey[LABEL_W-1:0];
			pair_count     <= rtally;
			last           <= 1'b0;
		end else if (cmd.sum_out) begin
			refused        <= refuse_q;
			distinct_pairs <= refuse_q ? 6'd0 : 6'(total_q);
			pair_before    <= '0;
			pair_after     <= '0;
			pair_count     <= '0;
			last           <= 1'b1;
		end
	end
endmodule
`default_nettype wire

// File: rtl/shifted_label_overlap_counter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shifted_label_overlap_counter_unit
// Counts (before, after) label overlaps between two volumes after shifting
// each before voxel by its label's lag.
// ----------------------------------------------------------------------------
// Usage:
//  Items are taken when start is high and busy is low. Voxel and lag loads
//  leave busy low, so loads can stream every cycle. A finish item raises
//  busy while the job runs: a product check over the axes and a compare,
//  then a walk over the voxel store with one read port shared by the
//  before and after reads, a binary lag search that then picks the shift,
//  the shifted address built axis by axis, and a binary pair table search;
//  a new pair moves the entries above its slot up one at a time to keep
//  the table sorted. If the job is not refused and the pair count fits the
//  room setting, emission shows each pair; then the summary (last high).
//  Every result is on the ports for one cycle with result_valid; there is no
//  back-pressure. Configuration transfers are always taken (cfg_ready high)
//  and belong to idle periods. Reset restores the register defaults and
//  empties the voxel, lag and pair counts; no clearing pass is needed.
// ----------------------------------------------------------------------------
module shifted_label_overlap_counter_unit #(
	parameter int MAX_VOXELS  = 4096,
	parameter int MAX_AXES    = 3,
	parameter int PAIR_LIMIT  = 63,
	parameter int LAG_ENTRIES = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire  [1:0]          opcode,
	input  wire  [31:0]         label_before,
	input  wire                 present_before,
	input  wire  [31:0]         label_after,
	input  wire                 present_after,
	input  wire  [31:0]         lag_label,
	input  wire  signed [12:0]  lag_step_0,
	input  wire  signed [12:0]  lag_step_1,
	input  wire  signed [12:0]  lag_step_2,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [2:0]          cfg_index,
	input  wire  [12:0]         cfg_data,
	output logic                result_valid,
	output logic                refused,
	output logic [5:0]          distinct_pairs,
	output logic [31:0]         pair_before,
	output logic [31:0]         pair_after,
	output logic [12:0]         pair_count,
	output logic                last
);
	import sloc_pkg::*;

	sloc_cmd_t cmd;
	sloc_sts_t sts;

	assign cfg_ready = 1'b1;

	sloc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	sloc_dpath #(
		.MAX_VOXELS  (MAX_VOXELS),
		.MAX_AXES    (MAX_AXES),
		.PAIR_LIMIT  (PAIR_LIMIT),
		.LAG_ENTRIES (LAG_ENTRIES)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.label_before   (label_before),
		.present_before (present_before),
		.label_after    (label_after),
		.present_after  (present_after),
		.lag_label      (lag_label),
		.lag_step_0     (lag_step_0),
		.lag_step_1     (lag_step_1),
		.lag_step_2     (lag_step_2),
		.result_valid   (result_valid),
		.refused        (refused),
		.distinct_pairs (distinct_pairs),
		.pair_before    (pair_before),
		.pair_after     (pair_after),
		.pair_count     (pair_count),
		.last           (last)
	);

`ifndef SYNTHESIS
	a_sum_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |-> !busy)
		else $error("summary shown while job still running");

	a_pair_inside_job: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |-> busy)
		else $error("pair entry outside a job");

	a_finish_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_FINISH) |=> busy)
		else $error("finish transfer did not start a job");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == OP_VOXEL || opcode == OP_LAG)) |=> !result_valid)
		else $error("load produced a result");
`endif
endmodule
`default_nettype wire
